/* hw/rtl/ira_pkg.sv */
// Shared constants and control types of the interval room allocator.
`default_nettype none

package ira_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int TIME_WIDTH = 32;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int COUNT_W    = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W    = ADDR_W + 2;

  typedef struct packed {
    logic capture;
    logic start_up;
    logic start_dn;
    logic set_ovf;
    logic place;
    logic rd_parent;
    logic up_eval;
    logic rd_left;
    logic rd_right;
    logic dn_eval;
    logic publish;
  } ira_cmd_t;

  typedef struct packed {
    logic need_room;
    logic full;
    logic at_root;
    logic up_move;
    logic no_child;
    logic dn_move;
    logic out_free;
  } ira_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ira_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/ira_ctrl.sv */
// Controller state machine that sequences heap decisions, sift-up and sift-down.
`default_nettype none

module ira_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ira_pkg::ira_sts_t sts,
  output ira_pkg::ira_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_UP     = 3'd2;
  localparam logic [2:0] ST_UP_CMP = 3'd3;
  localparam logic [2:0] ST_DN     = 3'd4;
  localparam logic [2:0] ST_DN_R   = 3'd5;
  localparam logic [2:0] ST_DN_CMP = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.need_room) begin
          if (sts.full) begin
            cmd.set_ovf = 1'b1;
            state_next  = ST_DONE;
          end else begin
            cmd.start_up = 1'b1;
            state_next   = ST_UP;
          end
        end else begin
          cmd.start_dn = 1'b1;
          state_next   = ST_DN;
        end
      end
      ST_UP: begin
        if (sts.at_root) begin
          cmd.place  = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmd.up_eval = 1'b1;
        state_next  = sts.up_move ? ST_UP : ST_DONE;
      end
      ST_DN: begin
        if (sts.no_child) begin
          cmd.place  = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.rd_left = 1'b1;
          state_next  = ST_DN_R;
        end
      end
      ST_DN_R: begin
        cmd.rd_right = 1'b1;
        state_next   = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd.dn_eval = 1'b1;
        state_next  = sts.dn_move ? ST_DN : ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ira_dp.sv */
// Datapath of the interval room allocator: heap memory, count, hole index and result register.
`default_nettype none

module ira_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ira_pkg::ira_cmd_t              cmd,
  output ira_pkg::ira_sts_t                   sts,
  input  wire logic [ira_pkg::TIME_WIDTH-1:0] start_time,
  input  wire logic [ira_pkg::TIME_WIDTH-1:0] finish_time,
  input  wire logic                           last_interval,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [ira_pkg::COUNT_W-1:0]    rooms_in_use,
  output logic                                overflow,
  output logic                                final_count
);

  logic [ira_pkg::TIME_WIDTH-1:0] start_q;
  logic [ira_pkg::TIME_WIDTH-1:0] finish_q;
  logic                           last_q;
  logic [ira_pkg::TIME_WIDTH-1:0] root_q;
  logic [ira_pkg::TIME_WIDTH-1:0] left_q;
  logic [ira_pkg::ADDR_W-1:0]     k;
  logic [ira_pkg::COUNT_W-1:0]    cnt;
  logic                           ovf;

  logic                           wr_en;
  logic [ira_pkg::ADDR_W-1:0]     rd_addr;
  logic [ira_pkg::TIME_WIDTH-1:0] wr_data;
  logic [ira_pkg::TIME_WIDTH-1:0] rd_data;

  logic [ira_pkg::ADDR_W-1:0]     parent;
  logic [ira_pkg::CHILD_W-1:0]    j;
  logic [ira_pkg::CHILD_W-1:0]    j1;
  logic [ira_pkg::CHILD_W-1:0]    cnt_ext;
  logic                           has_right;
  logic                           take_right;
  logic [ira_pkg::TIME_WIDTH-1:0] child_val;
  logic [ira_pkg::CHILD_W-1:0]    child_idx;

  ira_ram #(
    .WIDTH(ira_pkg::TIME_WIDTH),
    .DEPTH(ira_pkg::HEAP_DEPTH)
  ) u_heap (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(k),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign parent     = (k - ira_pkg::ADDR_W'(1)) >> 1;
  assign j          = {1'b0, k, 1'b1};
  assign j1         = j + ira_pkg::CHILD_W'(1);
  assign cnt_ext    = ira_pkg::CHILD_W'(cnt);
  assign has_right  = (j1 < cnt_ext);
  assign take_right = has_right && (left_q > rd_data);
  assign child_val  = take_right ? rd_data : left_q;
  assign child_idx  = take_right ? j1 : j;

  assign sts.need_room = (cnt == '0) || (start_q < root_q);
  assign sts.full      = (cnt == ira_pkg::COUNT_W'(ira_pkg::HEAP_DEPTH));
  assign sts.at_root   = (k == '0);
  assign sts.up_move   = (finish_q < rd_data);
  assign sts.no_child  = (j >= cnt_ext);
  assign sts.dn_move   = (finish_q > child_val);
  assign sts.out_free  = !out_valid || !out_stall;

  assign wr_en = cmd.place || cmd.up_eval || cmd.dn_eval;

  always_comb begin
    wr_data = finish_q;
    if (cmd.up_eval && sts.up_move) begin
      wr_data = rd_data;
    end else if (cmd.dn_eval && sts.dn_move) begin
      wr_data = child_val;
    end
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_parent) begin
      rd_addr = parent;
    end else if (cmd.rd_left) begin
      rd_addr = j[ira_pkg::ADDR_W-1:0];
    end else if (cmd.rd_right) begin
      rd_addr = j1[ira_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start_q  <= start_time;
      finish_q <= finish_time;
      last_q   <= last_interval;
    end
    if (wr_en && (k == '0)) begin
      root_q <= wr_data;
    end
    if (cmd.rd_right) begin
      left_q <= rd_data;
    end
    if (cmd.start_up) begin
      k <= cnt[ira_pkg::ADDR_W-1:0];
    end else if (cmd.start_dn) begin
      k <= '0;
    end else if (cmd.up_eval && sts.up_move) begin
      k <= parent;
    end else if (cmd.dn_eval && sts.dn_move) begin
      k <= child_idx[ira_pkg::ADDR_W-1:0];
    end
    if (cmd.publish) begin
      rooms_in_use <= cnt;
      overflow     <= ovf;
      final_count  <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish && last_q) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        if (cmd.start_up) begin
          cnt <= cnt + ira_pkg::COUNT_W'(1);
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= ira_pkg::COUNT_W'(ira_pkg::HEAP_DEPTH))
    else $error("room count exceeds heap depth");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.publish && last_q |=> (cnt == '0) && !ovf)
    else $error("set state not cleared after last beat");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.start_up |=> cnt == $past(cnt) + ira_pkg::COUNT_W'(1))
    else $error("insert did not grow the room count");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (rst)
    cmd.set_ovf |-> sts.full && sts.need_room)
    else $error("overflow flagged while a room was available");

endmodule

`default_nettype wire

/* hw/rtl/interval_room_allocator.sv */
// Top level of the interval room allocator: controller plus heap datapath.
// Intervals must arrive in ascending start order; each input beat yields one output
// beat carrying the number of rooms in use, a sticky overflow flag for the current set,
// and a copy of the last-interval mark, after which the set is cleared. Room finish
// times are kept as a binary min-heap in a RAM with one read and one write port, and
// that single read port sets the pace: opening a room sifts the new finish time up
// with one parent read per level, reusing one sifts it down with a left and a right child
// read per level, and the new finish time moves at most 10 levels with 1024 entries.
// The block accepts one item at a time; a finished result waits in the output register
// while the next input beat is taken.
`default_nettype none

module interval_room_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ira_pkg::TIME_WIDTH-1:0] start_time,
  input  wire logic [ira_pkg::TIME_WIDTH-1:0] finish_time,
  input  wire logic                           last_interval,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [ira_pkg::COUNT_W-1:0]    rooms_in_use,
  output logic                                overflow,
  output logic                                final_count
);

  ira_pkg::ira_cmd_t cmd;
  ira_pkg::ira_sts_t sts;

  ira_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  ira_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .start_time   (start_time),
    .finish_time  (finish_time),
    .last_interval(last_interval),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rooms_in_use (rooms_in_use),
    .overflow     (overflow),
    .final_count  (final_count)
  );

endmodule

`default_nettype wire

/* tb/sv/interval_room_allocator_test.sv */
// Self-checking testbench for the interval room allocator with a min-heap room predictor.
`timescale 1ns / 1ps

module interval_room_allocator_test;

  typedef struct {
    logic [ira_pkg::TIME_WIDTH-1:0] start;
    logic [ira_pkg::TIME_WIDTH-1:0] finish;
    logic                           last;
  } interval_t;

  typedef struct {
    logic [ira_pkg::COUNT_W-1:0] rooms;
    logic                        full_hit;
    logic                        closing;
  } room_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ira_pkg::TIME_WIDTH-1:0] start_time = '0;
  logic [ira_pkg::TIME_WIDTH-1:0] finish_time = '0;
  logic                           last_interval = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ira_pkg::COUNT_W-1:0]    rooms_in_use;
  logic                           overflow;
  logic                           final_count;

  interval_t    pending_intervals[$];
  room_result_t expected_rooms[$];
  interval_t    next_beat;
  room_result_t want;

  logic [ira_pkg::TIME_WIDTH-1:0] room_heap[ira_pkg::HEAP_DEPTH];
  int unsigned                    rooms_open = 0;
  logic                           rooms_short = 1'b0;

  logic in_taken = 1'b0;
  int   n_queued = 0;
  int   n_taken = 0;
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_token = 0;
  int   hold_ack = 0;
  int   hold_left = 0;

  interval_room_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_time   (start_time),
    .finish_time  (finish_time),
    .last_interval(last_interval),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rooms_in_use (rooms_in_use),
    .overflow     (overflow),
    .final_count  (final_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic room_result_t allocate_room(input logic [ira_pkg::TIME_WIDTH-1:0] s,
                                                 input logic [ira_pkg::TIME_WIDTH-1:0] f,
                                                 input logic fin);
    room_result_t                   r;
    int unsigned                    k;
    int unsigned                    p;
    int unsigned                    j;
    logic [ira_pkg::TIME_WIDTH-1:0] t;
    if (rooms_open == 0 || s < room_heap[0]) begin
      if (rooms_open >= ira_pkg::HEAP_DEPTH) begin
        rooms_short = 1'b1;
      end else begin
        k = rooms_open;
        room_heap[k] = f;
        rooms_open++;
        while (k > 0) begin
          p = (k - 1) / 2;
          if (!(room_heap[k] < room_heap[p])) break;
          t = room_heap[k];
          room_heap[k] = room_heap[p];
          room_heap[p] = t;
          k = p;
        end
      end
    end else begin
      room_heap[0] = f;
      k = 0;
      while (2 * k + 1 < rooms_open) begin
        j = 2 * k + 1;
        if (j + 1 < rooms_open && room_heap[j] > room_heap[j + 1]) j++;
        if (room_heap[k] <= room_heap[j]) break;
        t = room_heap[k];
        room_heap[k] = room_heap[j];
        room_heap[j] = t;
        k = j;
      end
    end
    r.rooms = ira_pkg::COUNT_W'(rooms_open);
    r.full_hit = rooms_short;
    r.closing = fin;
    if (fin) begin
      rooms_open = 0;
      rooms_short = 1'b0;
    end
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_intervals.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = pending_intervals.pop_front();
        in_valid <= 1'b1;
        start_time <= next_beat.start;
        finish_time <= next_beat.finish;
        last_interval <= next_beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_token != hold_ack) begin
      hold_ack <= hold_token;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_rooms.size() == 0) begin
          $error("unexpected result beat: rooms_in_use %0d", rooms_in_use);
          fail_count++;
        end else begin
          want = expected_rooms.pop_front();
          if (rooms_in_use !== want.rooms) begin
            $error("rooms_in_use expected %0d got %0d", want.rooms, rooms_in_use);
            fail_count++;
          end
          if (overflow !== want.full_hit) begin
            $error("overflow expected %0b got %0b", want.full_hit, overflow);
            fail_count++;
          end
          if (final_count !== want.closing) begin
            $error("final_count expected %0b got %0b", want.closing, final_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_rooms.push_back(allocate_room(start_time, finish_time, last_interval));
        n_taken++;
      end
    end
  end

  task automatic offer(input logic [ira_pkg::TIME_WIDTH-1:0] s,
                       input logic [ira_pkg::TIME_WIDTH-1:0] f,
                       input logic fin);
    interval_t iv;
    iv.start = s;
    iv.finish = f;
    iv.last = fin;
    pending_intervals.push_back(iv);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (!(n_taken == n_queued && expected_rooms.size() == 0)) @(posedge clk);
  endtask

  task automatic queue_sets(input int n);
    int                             left;
    int                             len;
    logic [ira_pkg::TIME_WIDTH-1:0] t;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(40, 1);
        if (len > left) len = left;
        t = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1000);
        for (int i = 0; i < len; i++) begin
          t = t + $urandom_range(15);
          offer(t, t + $urandom_range(80, 1), i == len - 1);
        end
        left -= len;
      end else begin
        offer($urandom(), $urandom(), $urandom_range(3) == 0);
        left--;
      end
    end
  endtask

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer(32'd0, 32'd0, 1'b0);
    offer(32'd0, 32'hFFFF_FFFF, 1'b0);
    offer(32'd5, 32'd10, 1'b0);
    offer(32'd10, 32'd20, 1'b0);
    offer(32'd10, 32'd20, 1'b0);
    offer(32'd20, 32'd30, 1'b0);
    offer(32'd20, 32'd20, 1'b0);
    offer(32'd3, 32'd7, 1'b0);
    offer(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    offer(32'hFFFF_FFFF, 32'd0, 1'b0);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer(32'd0, 32'd5, 1'b1);
    offer(32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0);
    offer(32'h5A5A_5A5A, 32'h5A5A_5A5B, 1'b1);
    wait_drained();

    hold_token = hold_token + 1;
    queue_sets(30);
    wait_drained();

    send_idle_pct = 85;
    queue_sets(140);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 85;
    queue_sets(140);
    wait_drained();
    send_idle_pct = 9;
    recv_stall_pct = 9;
    queue_sets(140);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_sets(140);

    while (n_taken != n_queued) @(posedge clk);
    for (guard = 0; guard < 5000 && expected_rooms.size() != 0; guard++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_rooms.size() != 0) begin
      $error("%0d expected results never arrived", expected_rooms.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("interval_room_allocator_test OK");
    end else begin
      $display("interval_room_allocator_test NOT OK");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("interval_room_allocator_test NOT OK");
    $finish;
  end

endmodule
